/* design/rci_pkg.sv */
`default_nettype none

package rci_pkg;

	localparam int CH_W = 8;
	localparam int SUM_W = 10;
	localparam int DEN_W = 18;
	localparam int NUM_W = 24;
	localparam int OUT_W = 16;

	localparam int CHROMA_SCALE = 65025;
	localparam int DEN_SLOPE = 254;
	localparam int DEN_BIAS = 255;
	localparam int INT_DIVISOR = 765;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [NUM_W-1:0] num_r;
		logic [NUM_W-1:0] num_g;
		logic [DEN_W-1:0] den;
		logic             fixed;
	} job_t;

endpackage

`default_nettype wire

/* design/rci_if.sv */
`default_nettype none

interface rci_pixel_if import rci_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] red;

	modport source (output valid, blue, green, red, input ready);
	modport sink (input valid, blue, green, red, output ready);
endinterface

interface rci_cfg_if;
	logic valid;
	logic ready;
	logic output_fixed;

	modport source (output valid, output_fixed, input ready);
	modport sink (input valid, output_fixed, output ready);
endinterface

interface rci_result_if import rci_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] chroma_r;
	logic [OUT_W-1:0] chroma_g;
	logic [OUT_W-1:0] intensity;

	modport source (output valid, chroma_r, chroma_g, intensity, input ready);
	modport sink (input valid, chroma_r, chroma_g, intensity, output ready);
endinterface

`default_nettype wire

/* design/rci_front.sv */
`default_nettype none

module rci_front import rci_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        output_fixed,
	rci_pixel_if.sink   pixel,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);

	logic [SUM_W-1:0] sum;
	logic [DEN_W-1:0] den;
	logic             job_valid_s1;
	job_t             job_s1;

	assign sum = SUM_W'(pixel.blue) + SUM_W'(pixel.green) + SUM_W'(pixel.red);
	assign den = DEN_W'(DEN_W'(sum) * DEN_W'(DEN_SLOPE)) + DEN_W'(DEN_BIAS);

	assign pixel.ready = !job_valid_s1 || job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			job_valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			job_s1.num_r <= NUM_W'(NUM_W'(pixel.red) * NUM_W'(CHROMA_SCALE));
			job_s1.num_g <= NUM_W'(NUM_W'(pixel.green) * NUM_W'(CHROMA_SCALE));
			job_s1.den   <= den;
			job_s1.fixed <= output_fixed;
		end
	end

	assign job_valid = job_valid_s1;
	assign job = job_s1;

endmodule

`default_nettype wire

/* design/rci_queue.sv */
`default_nettype none

module rci_queue import rci_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  job_t in_job,
	output logic out_valid,
	input  logic out_ready,
	output job_t out_job
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign in_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_job = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_job;
		end
	end

endmodule

`default_nettype wire

/* design/rci_back.sv */
`default_nettype none

module rci_back import rci_pkg::*; #(
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	rci_result_if.source result
);

	localparam int QW = CH_W + 1 + FRACTION_BITS;
	localparam int NSTG = QW;
	localparam int RC_W = DEN_W + 1;

	// The intensity quotient is exact for every dividend below 2^27 with this reciprocal.
	localparam int RECIP_SHIFT = 36;
	localparam int RECIP_W = 27;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) +
		64'(INT_DIVISOR) - 64'd1) / 64'(INT_DIVISOR));

	typedef struct packed {
		logic                   fixed;
		logic [DEN_W-1:0]       den;
		logic [RC_W+QW-1:0]     acc_r;
		logic [RC_W+QW-1:0]     acc_g;
		logic [QW-1:0]          quo_i;
	} stage_t;

	function automatic logic [RC_W+QW-1:0] step_c(
		input logic [RC_W+QW-1:0] acc,
		input logic [DEN_W-1:0]   den
	);
		logic [RC_W+QW-1:0] t;
		logic [RC_W-1:0]    hi;
		t = acc << 1;
		hi = t[RC_W+QW-1:QW];
		if (hi >= RC_W'(den)) begin
			t[RC_W+QW-1:QW] = hi - RC_W'(den);
			t[0] = 1'b1;
		end
		return t;
	endfunction

	function automatic stage_t step(input stage_t s);
		stage_t n;
		n = s;
		n.acc_r = step_c(s.acc_r, s.den);
		n.acc_g = step_c(s.acc_g, s.den);
		return n;
	endfunction

	// The quotient carries one extra fraction bit so that both modes share it.
	function automatic logic [OUT_W-1:0] format(input logic [QW-1:0] q, input logic fixed);
		logic [CH_W+1:0] rnd;
		rnd = (CH_W+2)'(q[QW-1:FRACTION_BITS]) + 1'b1;
		if (fixed) begin
			return OUT_W'(q[QW-1:1]);
		end
		return OUT_W'(rnd[CH_W+1:1]);
	endfunction

	stage_t                     first;
	logic [DEN_W+RECIP_W-1:0]   int_prod;
	stage_t                     stage_s [NSTG];
	logic [NSTG-1:0]            vld_s;
	logic                       res_valid_q;
	logic [OUT_W-1:0]           chroma_r_q;
	logic [OUT_W-1:0]           chroma_g_q;
	logic [OUT_W-1:0]           intensity_q;
	logic                       adv;

	always_comb begin
		int_prod    = (DEN_W+RECIP_W)'(job.den) * (DEN_W+RECIP_W)'(RECIP);
		first.fixed = job.fixed;
		first.den   = job.den;
		first.acc_r = {RC_W'(job.num_r[NUM_W-1:CH_W]), job.num_r[CH_W-1:0],
			{(FRACTION_BITS+1){1'b0}}};
		first.acc_g = {RC_W'(job.num_g[NUM_W-1:CH_W]), job.num_g[CH_W-1:0],
			{(FRACTION_BITS+1){1'b0}}};
		first.quo_i = int_prod[RECIP_SHIFT-FRACTION_BITS-1 +: QW];
	end

	assign adv = !res_valid_q || result.ready;
	assign job_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s       <= {vld_s[NSTG-2:0], job_valid};
			res_valid_q <= vld_s[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stage_s[0] <= step(first);
			for (int k = 1; k < NSTG; k++) begin
				stage_s[k] <= step(stage_s[k-1]);
			end
			chroma_r_q  <= format(stage_s[NSTG-1].acc_r[QW-1:0], stage_s[NSTG-1].fixed);
			chroma_g_q  <= format(stage_s[NSTG-1].acc_g[QW-1:0], stage_s[NSTG-1].fixed);
			intensity_q <= format(stage_s[NSTG-1].quo_i, stage_s[NSTG-1].fixed);
		end
	end

	assign result.valid     = res_valid_q;
	assign result.chroma_r  = chroma_r_q;
	assign result.chroma_g  = chroma_g_q;
	assign result.intensity = intensity_q;

endmodule

`default_nettype wire

/* design/rgb_to_chromaticity_intensity.sv */
// Throughput is one pixel per cycle while the result side does not stall, set by the restoring
// divider pipeline of 9 + FRACTION_BITS stages for the two chroma lanes; the intensity is a
// reciprocal product carried alongside. A four-entry queue between the input stage and the
// divider absorbs output back-pressure. The asynchronous active-low reset empties every stage
// and the queue and selects rounded output.
`default_nettype none

module rgb_to_chromaticity_intensity import rci_pkg::*; #(
	parameter int FRACTION_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	rci_pixel_if.sink     pixel,
	rci_cfg_if.sink       cfg,
	rci_result_if.source  result
);

	localparam int MIN_FIX_INT = (2 ** FRACTION_BITS) / 3;

	logic output_fixed_q;
	logic fj_valid;
	logic fj_ready;
	job_t fj_job;
	logic bj_valid;
	logic bj_ready;
	job_t bj_job;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_fixed_q <= 1'b0;
		end else if (cfg.valid) begin
			output_fixed_q <= cfg.output_fixed;
		end
	end

	rci_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.output_fixed (output_fixed_q),
		.pixel        (pixel),
		.job_valid    (fj_valid),
		.job_ready    (fj_ready),
		.job          (fj_job)
	);

	rci_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fj_valid),
		.in_ready  (fj_ready),
		.in_job    (fj_job),
		.out_valid (bj_valid),
		.out_ready (bj_ready),
		.out_job   (bj_job)
	);

	rci_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bj_valid),
		.job_ready (bj_ready),
		.job       (bj_job),
		.result    (result)
	);

	a_rounded_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !output_fixed_q |-> result.chroma_r <= OUT_W'(255) &&
		result.chroma_g <= OUT_W'(255) && result.intensity <= OUT_W'(255))
		else $error("rounded result out of range");

	a_rounded_chroma_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !output_fixed_q |->
		(17'(result.chroma_r) + 17'(result.chroma_g)) <= 17'd256)
		else $error("chroma sum exceeds full scale");

	a_fixed_intensity_floor: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && output_fixed_q |-> result.intensity >= OUT_W'(MIN_FIX_INT))
		else $error("fixed intensity below minimum");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import rci_pkg::*;

	localparam int FRAC_BITS = 8;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [OUT_W-1:0] chroma_r;
		logic [OUT_W-1:0] chroma_g;
		logic [OUT_W-1:0] intensity;
	} chroma_t;

	logic clk;
	logic arst_n;

	rci_pixel_if pixel_bus ();
	rci_cfg_if cfg_bus ();
	rci_result_if result_bus ();

	rgb_to_chromaticity_intensity #(.FRACTION_BITS(FRAC_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel_bus),
		.cfg(cfg_bus),
		.result(result_bus)
	);

	chroma_t pending_chroma[$];
	chroma_t head_chroma;
	int error_count = 0;
	bit mode_fixed = 1'b0;
	bit src_gaps = 1'b1;
	bit sink_gaps = 1'b1;
	int unsigned ready_hold_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [OUT_W-1:0] scaled_div(input longint unsigned num,
			input longint unsigned den, input bit fixed);
		longint unsigned q;
		if (fixed) begin
			q = (num << FRAC_BITS) / den;
		end else begin
			q = (2 * num + den) / (2 * den);
		end
		return q[OUT_W-1:0];
	endfunction

	function automatic chroma_t predict_chroma(input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] r, input bit fixed);
		chroma_t e;
		longint unsigned sum;
		longint unsigned den;
		sum = b;
		sum += g;
		sum += r;
		den = 254 * sum + 255;
		e.chroma_r = scaled_div(65025 * longint'(r), den, fixed);
		e.chroma_g = scaled_div(65025 * longint'(g), den, fixed);
		e.intensity = scaled_div(den, 765, fixed);
		return e;
	endfunction

	function automatic logic [CH_W-1:0] rand_channel();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return CH_W'($urandom_range(0, 255));
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [OUT_W-1:0] exp_v,
			input logic [OUT_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_chroma.size() == 0) begin
				$display("%0t: result with nothing expected, actual %0d %0d %0d", $time,
					result_bus.chroma_r, result_bus.chroma_g, result_bus.intensity);
				error_count++;
			end else begin
				head_chroma = pending_chroma.pop_front();
				check_field("chroma_r", head_chroma.chroma_r, result_bus.chroma_r);
				check_field("chroma_g", head_chroma.chroma_g, result_bus.chroma_g);
				check_field("intensity", head_chroma.intensity, result_bus.intensity);
			end
		end
	end

	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold_cycles != 0) begin
				result_bus.ready = 1'b0;
				repeat (ready_hold_cycles) @(negedge clk);
				ready_hold_cycles = 0;
			end else if (sink_gaps && $urandom_range(0, 11) == 0) begin
				result_bus.ready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			result_bus.ready = 1'b1;
		end
	end

	task automatic send_pixel(input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] r);
		@(negedge clk);
		if (src_gaps && $urandom_range(0, 7) == 0) begin
			pixel_bus.valid = 1'b0;
			pixel_bus.blue = CH_W'($urandom);
			pixel_bus.green = CH_W'($urandom);
			pixel_bus.red = CH_W'($urandom);
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		pixel_bus.valid = 1'b1;
		pixel_bus.blue = b;
		pixel_bus.green = g;
		pixel_bus.red = r;
		@(posedge clk);
		while (!pixel_bus.ready) @(posedge clk);
		pending_chroma.push_back(predict_chroma(b, g, r, mode_fixed));
	endtask

	task automatic pixel_quiet();
		@(negedge clk);
		pixel_bus.valid = 1'b0;
	endtask

	task automatic write_mode(input bit fixed);
		wait (pending_chroma.size() == 0);
		@(negedge clk);
		pixel_bus.valid = 1'b0;
		cfg_bus.valid = 1'b1;
		cfg_bus.output_fixed = fixed;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		mode_fixed = fixed;
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic test_directed();
		logic [3*CH_W-1:0] corner[14];
		corner = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h010101,
			24'h800000, 24'h008000, 24'h000080, 24'h7F7F7F, 24'hFF00FF, 24'h55AA55,
			24'hAA55AA, 24'h000001};
		foreach (corner[i]) begin
			send_pixel(corner[i][23:16], corner[i][15:8], corner[i][7:0]);
		end
		pixel_quiet();
	endtask

	task automatic test_random_stream(input int count);
		for (int i = 0; i < count; i++) begin
			send_pixel(rand_channel(), rand_channel(), rand_channel());
		end
		pixel_quiet();
	endtask

	// The result side stalls long enough for the pipeline and its queue to fill,
	// so the input has to hold off while items keep being offered.
	task automatic test_backpressure();
		bit saved_gaps;
		saved_gaps = src_gaps;
		src_gaps = 1'b0;
		@(posedge clk);
		ready_hold_cycles = 80;
		test_random_stream(60);
		src_gaps = saved_gaps;
	endtask

	task automatic test_drain_pause();
		for (int burst = 0; burst < 3; burst++) begin
			test_random_stream(30);
			wait (pending_chroma.size() == 0);
		end
	endtask

	task automatic test_full_rate();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		test_random_stream(60);
		write_mode(1'b1);
		test_random_stream(60);
	endtask

	initial begin
		arst_n = 1'b0;
		pixel_bus.valid = 1'b0;
		pixel_bus.blue = '0;
		pixel_bus.green = '0;
		pixel_bus.red = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.output_fixed = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		write_mode(1'b1);
		test_directed();
		write_mode(1'b0);
		test_random_stream(220);
		write_mode(1'b1);
		test_random_stream(220);
		test_backpressure();
		write_mode(1'b1);
		write_mode(1'b0);
		test_drain_pause();
		write_mode(1'b1);
		test_random_stream(100);
		write_mode(1'b0);
		test_full_rate();

		wait (pending_chroma.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, pending_chroma.size());
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
